/* rtl/core/wsp_pkg.sv */
`timescale 1ns / 1ps

package wsp_pkg;

    // parser phases, one-hot
    typedef enum logic [6:0] {
        PH_RIFF = 7'b0000001,
        PH_HDR  = 7'b0000010,
        PH_FMT  = 7'b0000100,
        PH_SKIP = 7'b0001000,
        PH_PAD  = 7'b0010000,
        PH_DATA = 7'b0100000,
        PH_DONE = 7'b1000000
    } phase_t;

    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TRUNCATED   = 3'd1;
    localparam logic [2:0] ST_NOT_RIFF    = 3'd2;
    localparam logic [2:0] ST_FMT_SHORT   = 3'd3;
    localparam logic [2:0] ST_MISSING     = 3'd4;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd5;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [31:0] FMT_BODY_LEN = 32'd16;
    localparam logic [15:0] PCM_CODE     = 16'd1;
    localparam logic [15:0] PCM_BITS     = 16'd16;

    localparam logic [6:0] VOLUME_RESET = 7'd10;
    localparam logic       REG_VOLUME   = 1'b0;

    // floor(m / 100) = (m * DIV_MULT) >> DIV_SHIFT, exact for m < 2**22
    localparam int          MAG_W     = 22;
    localparam int          DIV_SHIFT = 29;
    localparam logic [22:0] DIV_MULT  = 23'd5368710;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic [1:0]       kind;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic             channel;
        logic [1:0]       channel_count;
        logic [31:0]      rate_hz;
        logic [2:0]       status;
        logic             last;
    } result_t;

    function automatic result_t end_result(input logic [2:0] st);
        result_t r;
        r = '0;
        r.kind = KIND_END;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

endpackage

/* rtl/core/wav_stream_parse_and_volume.sv */
`timescale 1ns / 1ps

// WAV byte-stream parser with volume. One file byte is taken per clock cycle while
// byte_stall is low, with no gaps needed between bytes. The RIFF/WAVE header is checked,
// chunks are walked (unknown chunks and pad bytes skipped), the fmt fields are captured
// and checked when the data chunk starts, and each 16-bit little-endian sample is scaled
// by the volume setting in percent over 100, truncated toward zero and saturated. The
// parser writes a staging register and the divide by 100 (a constant reciprocal multiply)
// writes the output register. Bytes that cause no result use no slot. byte_stall rises
// only when both the staging and output registers hold results and result_stall is high.
// The volume register sits at byte address 0 of the APB port (reset 10); the user must
// write it only while no transaction is in flight; the block does not enforce it.
module wav_stream_parse_and_volume (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         data_byte,
    input  logic               file_end,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         kind,
    output logic signed [15:0] sample,
    output logic               channel,
    output logic [1:0]         channel_count,
    output logic [31:0]        rate_hz,
    output logic [2:0]         status,
    output logic               last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import wsp_pkg::*;

    logic [6:0]  vol_reg;

    phase_t      phase_reg,     phase_next;
    logic [31:0] count_reg,     count_next;
    logic [31:0] tag_reg,       tag_next;
    logic [31:0] len_reg,       len_next;
    logic        fmt_seen_reg,  fmt_seen_next;
    logic [15:0] pcm_reg,       pcm_next;
    logic [15:0] chans_reg,     chans_next;
    logic [31:0] rate_reg,      rate_next;
    logic [15:0] bits_reg,      bits_next;
    logic [7:0]  low_reg,       low_next;
    logic [31:0] left_reg,      left_next;
    logic        toggle_reg,    toggle_next;

    result_t     res;
    logic        res_hit;

    result_t     stage_reg;
    logic        stage_valid_reg;

    logic        byte_acc;
    logic        out_free;

    logic [MAG_W+22:0] quot_full;
    logic [15:0]       quot;
    logic signed [15:0] scaled;

    // ---------------- configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VOLUME) ? {25'd0, vol_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg <= VOLUME_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_VOLUME)
        begin
            vol_reg <= pwdata[6:0];
        end
    end

    // ---------------- handshake
    assign out_free   = !result_valid || !result_stall;
    assign byte_stall = stage_valid_reg && !out_free;
    assign byte_acc   = byte_valid && !byte_stall;

    // ---------------- parser
    always_comb
    begin
        logic [31:0] cnt_inc;
        logic [31:0] left_dec;
        logic [15:0] raw;
        logic [15:0] raw_mag;
        logic [22:0] prod;
        logic        go_hdr;
        logic [3:0]  n;

        phase_next    = phase_reg;
        count_next    = count_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        fmt_seen_next = fmt_seen_reg;
        pcm_next      = pcm_reg;
        chans_next    = chans_reg;
        rate_next     = rate_reg;
        bits_next     = bits_reg;
        low_next      = low_reg;
        left_next     = left_reg;
        toggle_next   = toggle_reg;
        res           = '0;
        res_hit       = 1'b0;
        go_hdr        = 1'b0;

        cnt_inc  = count_reg + 32'd1;
        left_dec = left_reg - 32'd1;
        n        = count_reg[3:0];
        raw      = {data_byte, low_reg};
        raw_mag  = raw[15] ? (~raw + 16'd1) : raw;
        prod     = {7'd0, raw_mag} * {16'd0, vol_reg};

        case (phase_reg)
            PH_RIFF:
            begin
                if (count_reg < 32'd4)
                    tag_next = {tag_reg[23:0], data_byte};
                else if (count_reg >= 32'd8)
                    len_next = {len_reg[23:0], data_byte};
                count_next = cnt_inc;
                if (cnt_inc == 32'd12)
                begin
                    if (tag_next == TAG_RIFF && len_next == TAG_WAVE)
                    begin
                        go_hdr = 1'b1;
                    end
                    else
                    begin
                        res        = end_result(ST_NOT_RIFF);
                        res_hit    = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_HDR:
            begin
                if (count_reg < 32'd4)
                    tag_next = {tag_reg[23:0], data_byte};
                else
                    len_next[8*count_reg[1:0] +: 8] = data_byte;
                count_next = cnt_inc;
                if (cnt_inc == 32'd8)
                begin
                    if (tag_next == TAG_FMT)
                    begin
                        if (len_next < FMT_BODY_LEN)
                        begin
                            res        = end_result(ST_FMT_SHORT);
                            res_hit    = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_FMT;
                            count_next = 32'd0;
                        end
                    end
                    else if (tag_next == TAG_DATA)
                    begin
                        if (!fmt_seen_reg)
                        begin
                            res        = end_result(ST_MISSING);
                            res_hit    = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (pcm_reg != PCM_CODE || bits_reg != PCM_BITS ||
                                 (chans_reg != 16'd1 && chans_reg != 16'd2))
                        begin
                            res        = end_result(ST_UNSUPPORTED);
                            res_hit    = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            left_next         = len_next;
                            toggle_next       = 1'b0;
                            count_next        = 32'd0;
                            res.kind          = KIND_FORMAT;
                            res.channel_count = chans_reg[1:0];
                            res.rate_hz       = rate_reg;
                            res.last          = (len_next == 32'd0);
                            res_hit           = 1'b1;
                            phase_next        = (len_next == 32'd0) ? PH_DONE : PH_DATA;
                        end
                    end
                    else
                    begin
                        count_next = 32'd0;
                        if (len_next != 32'd0)
                            phase_next = PH_SKIP;
                        else if (len_next[0])
                            phase_next = PH_PAD;
                        else
                            go_hdr = 1'b1;
                    end
                end
            end
            PH_FMT:
            begin
                if (n < 4'd2)
                    pcm_next[8*n[0] +: 8] = data_byte;
                else if (n < 4'd4)
                    chans_next[8*n[0] +: 8] = data_byte;
                else if (n < 4'd8)
                    rate_next[8*n[1:0] +: 8] = data_byte;
                else if (n >= 4'd14)
                    bits_next[8*n[0] +: 8] = data_byte;
                count_next = cnt_inc;
                if (cnt_inc == FMT_BODY_LEN)
                begin
                    fmt_seen_next = 1'b1;
                    if (len_reg != FMT_BODY_LEN)
                        phase_next = PH_SKIP;
                    else if (len_reg[0])
                        phase_next = PH_PAD;
                    else
                        go_hdr = 1'b1;
                end
            end
            PH_SKIP:
            begin
                count_next = cnt_inc;
                if (cnt_inc >= len_reg)
                begin
                    if (len_reg[0])
                        phase_next = PH_PAD;
                    else
                        go_hdr = 1'b1;
                end
            end
            PH_PAD:
            begin
                go_hdr = 1'b1;
            end
            PH_DATA:
            begin
                if (left_reg == 32'd0)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    left_next = left_dec;
                    if (!count_reg[0])
                    begin
                        low_next   = data_byte;
                        count_next = 32'd1;
                        // odd trailing byte exhausts the data size
                        if (left_dec == 32'd0)
                        begin
                            res        = end_result(ST_OK);
                            res_hit    = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                    else
                    begin
                        res.kind          = KIND_SAMPLE;
                        res.neg           = raw[15];
                        res.mag           = prod[MAG_W-1:0];
                        res.channel       = toggle_reg;
                        res.channel_count = chans_reg[1:0];
                        res.rate_hz       = rate_reg;
                        res.last          = (left_dec == 32'd0);
                        res_hit           = 1'b1;
                        if (chans_reg == 16'd2)
                            toggle_next = ~toggle_reg;
                        count_next = 32'd0;
                        if (left_dec == 32'd0)
                            phase_next = PH_DONE;
                    end
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (go_hdr)
        begin
            phase_next = PH_HDR;
            count_next = 32'd0;
            tag_next   = 32'd0;
            len_next   = 32'd0;
        end

        if (file_end)
        begin
            if (res_hit)
            begin
                res.last = 1'b1;
            end
            else
            begin
                res_hit = 1'b1;
                case (phase_next)
                    PH_RIFF, PH_FMT: res = end_result(ST_TRUNCATED);
                    PH_HDR:
                        res = end_result((count_next == 32'd0) ? ST_MISSING : ST_TRUNCATED);
                    PH_SKIP, PH_PAD: res = end_result(ST_MISSING);
                    PH_DATA: res = end_result(ST_OK);
                    default: res_hit = 1'b0;
                endcase
            end
            phase_next    = PH_RIFF;
            count_next    = 32'd0;
            tag_next      = 32'd0;
            len_next      = 32'd0;
            fmt_seen_next = 1'b0;
            pcm_next      = 16'd0;
            chans_next    = 16'd0;
            rate_next     = 32'd0;
            bits_next     = 16'd0;
            low_next      = 8'd0;
            left_next     = 32'd0;
            toggle_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RIFF;
            count_reg    <= 32'd0;
            tag_reg      <= 32'd0;
            len_reg      <= 32'd0;
            fmt_seen_reg <= 1'b0;
            pcm_reg      <= 16'd0;
            chans_reg    <= 16'd0;
            rate_reg     <= 32'd0;
            bits_reg     <= 16'd0;
            low_reg      <= 8'd0;
            left_reg     <= 32'd0;
            toggle_reg   <= 1'b0;
        end
        else if (byte_acc)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            tag_reg      <= tag_next;
            len_reg      <= len_next;
            fmt_seen_reg <= fmt_seen_next;
            pcm_reg      <= pcm_next;
            chans_reg    <= chans_next;
            rate_reg     <= rate_next;
            bits_reg     <= bits_next;
            low_reg      <= low_next;
            left_reg     <= left_next;
            toggle_reg   <= toggle_next;
        end
    end

    // ---------------- staging register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!stage_valid_reg || out_free)
        begin
            stage_valid_reg <= byte_acc && res_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_acc && res_hit)
        begin
            stage_reg <= res;
        end
    end

    // ---------------- divide by 100 and saturate
    assign quot_full = {1'b0, stage_reg.mag} * {{MAG_W{1'b0}}, DIV_MULT};
    assign quot      = quot_full[DIV_SHIFT +: 16];

    always_comb
    begin
        if (!stage_reg.neg)
            scaled = (quot > 16'd32767) ? SAMPLE_MAX : $signed(quot);
        else
            scaled = (quot > 16'd32768) ? SAMPLE_MIN : $signed(~quot + 16'd1);
    end

    // ---------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && stage_valid_reg)
        begin
            kind          <= stage_reg.kind;
            sample        <= scaled;
            channel       <= stage_reg.channel;
            channel_count <= stage_reg.channel_count;
            rate_hz       <= stage_reg.rate_hz;
            status        <= stage_reg.status;
            last          <= stage_reg.last;
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import wsp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_BYTES   = 90;
    localparam int PERCENT_SCALE = 100;

    // kinds of damage applied to a generated file
    localparam int FLAW_NONE      = 0;
    localparam int FLAW_BAD_RIFF  = 1;
    localparam int FLAW_BAD_WAVE  = 2;
    localparam int FLAW_SHORT_FMT = 3;
    localparam int FLAW_NO_FMT    = 4;
    localparam int FLAW_BAD_CODE  = 5;
    localparam int FLAW_BAD_BITS  = 6;
    localparam int FLAW_BAD_CHANS = 7;
    localparam int FLAW_REFMT     = 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] sample;
        logic        channel;
        logic [1:0]  channel_count;
        logic [31:0] rate_hz;
        logic [2:0]  status;
        logic        last;
    } wav_out_t;

    class wav_volume_checker;
        phase_t      phase;
        logic [31:0] count;
        logic [31:0] tag;
        logic [31:0] clen;
        logic [31:0] left;
        logic [31:0] rate;
        logic [15:0] fmt_code;
        logic [15:0] chans;
        logic [15:0] depth_bits;
        logic [7:0]  low;
        logic        fmt_ok;
        logic        slot;
        logic [6:0]  volume;
        wav_out_t    due_results[$];
        int          mismatch_count;

        function new();
            volume = VOLUME_RESET;
            mismatch_count = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_RIFF;
            count = '0;
            tag = '0;
            clen = '0;
            left = '0;
            rate = '0;
            fmt_code = '0;
            chans = '0;
            depth_bits = '0;
            low = '0;
            fmt_ok = 1'b0;
            slot = 1'b0;
        endfunction

        function void to_header();
            phase = PH_HDR;
            count = '0;
            tag = '0;
            clen = '0;
        endfunction

        function void chunk_done();
            if (clen[0])
            begin
                phase = PH_PAD;
            end
            else
            begin
                to_header();
            end
        endfunction

        function bit abort_with(input logic [2:0] st, output wav_out_t r);
            r = '0;
            r.kind = KIND_END;
            r.status = st;
            r.last = 1'b1;
            phase = PH_DONE;
            return 1'b1;
        endfunction

        function logic [15:0] scaled(input logic [15:0] raw);
            int s;
            int v;
            s = $signed(raw);
            v = s * int'(volume) / PERCENT_SCALE;
            if (v > int'(SAMPLE_MAX))
            begin
                v = int'(SAMPLE_MAX);
            end
            else if (v < int'(SAMPLE_MIN))
            begin
                v = int'(SAMPLE_MIN);
            end
            return v[15:0];
        endfunction

        function bit open_chunk(output wav_out_t r);
            r = '0;
            if (tag == TAG_FMT)
            begin
                if (clen < FMT_BODY_LEN)
                begin
                    return abort_with(ST_FMT_SHORT, r);
                end
                phase = PH_FMT;
                count = '0;
                return 1'b0;
            end
            if (tag == TAG_DATA)
            begin
                if (!fmt_ok)
                begin
                    return abort_with(ST_MISSING, r);
                end
                if (fmt_code != PCM_CODE || depth_bits != PCM_BITS || (chans != 1 && chans != 2))
                begin
                    return abort_with(ST_UNSUPPORTED, r);
                end
                left = clen;
                slot = 1'b0;
                count = '0;
                r.kind = KIND_FORMAT;
                r.channel_count = chans[1:0];
                r.rate_hz = rate;
                r.last = (left == 0);
                phase = (left == 0) ? PH_DONE : PH_DATA;
                return 1'b1;
            end
            count = '0;
            if (clen == 0)
            begin
                chunk_done();
            end
            else
            begin
                phase = PH_SKIP;
            end
            return 1'b0;
        endfunction

        function bit parse(input logic [7:0] b, output wav_out_t r);
            logic [31:0] n;
            n = count;
            r = '0;
            case (phase)
                PH_RIFF:
                begin
                    if (n < 4)
                    begin
                        tag = {tag[23:0], b};
                    end
                    else if (n >= 8)
                    begin
                        clen = {clen[23:0], b};
                    end
                    count = n + 1;
                    if (count == 12)
                    begin
                        if (tag == TAG_RIFF && clen == TAG_WAVE)
                        begin
                            to_header();
                            return 1'b0;
                        end
                        return abort_with(ST_NOT_RIFF, r);
                    end
                    return 1'b0;
                end
                PH_HDR:
                begin
                    // tag arrives big-endian, length little-endian
                    if (n < 4)
                    begin
                        tag = {tag[23:0], b};
                    end
                    else
                    begin
                        clen[8*n[1:0] +: 8] = b;
                    end
                    count = n + 1;
                    if (count == 8)
                    begin
                        return open_chunk(r);
                    end
                    return 1'b0;
                end
                PH_FMT:
                begin
                    if (n < 2)
                    begin
                        fmt_code[8*n[0] +: 8] = b;
                    end
                    else if (n < 4)
                    begin
                        chans[8*n[0] +: 8] = b;
                    end
                    else if (n < 8)
                    begin
                        rate[8*n[1:0] +: 8] = b;
                    end
                    else if (n >= 14)
                    begin
                        depth_bits[8*n[0] +: 8] = b;
                    end
                    count = n + 1;
                    if (count == FMT_BODY_LEN)
                    begin
                        fmt_ok = 1'b1;
                        // longer fmt chunks keep counting from 16 while skipping
                        if (clen == FMT_BODY_LEN)
                        begin
                            chunk_done();
                        end
                        else
                        begin
                            phase = PH_SKIP;
                        end
                    end
                    return 1'b0;
                end
                PH_SKIP:
                begin
                    count = n + 1;
                    if (count >= clen)
                    begin
                        chunk_done();
                    end
                    return 1'b0;
                end
                PH_PAD:
                begin
                    to_header();
                    return 1'b0;
                end
                PH_DATA:
                begin
                    if (left == 0)
                    begin
                        phase = PH_DONE;
                        return 1'b0;
                    end
                    left = left - 1;
                    if (!n[0])
                    begin
                        low = b;
                        count = 1;
                        // odd trailing byte ends the data chunk
                        if (left == 0)
                        begin
                            return abort_with(ST_OK, r);
                        end
                        return 1'b0;
                    end
                    r.kind = KIND_SAMPLE;
                    r.sample = scaled({b, low});
                    r.channel = slot;
                    r.channel_count = chans[1:0];
                    r.rate_hz = rate;
                    r.last = (left == 0);
                    if (chans == 2)
                    begin
                        slot = ~slot;
                    end
                    count = '0;
                    if (left == 0)
                    begin
                        phase = PH_DONE;
                    end
                    return 1'b1;
                end
                default:
                begin
                    return 1'b0;
                end
            endcase
        endfunction

        function void take_byte(input logic [7:0] b, input logic fe);
            wav_out_t r;
            bit       got;
            got = parse(b, r);
            if (fe)
            begin
                if (got)
                begin
                    r.last = 1'b1;
                end
                else
                begin
                    case (phase)
                        PH_RIFF, PH_FMT: got = abort_with(ST_TRUNCATED, r);
                        PH_HDR:          got = abort_with((count == 0) ? ST_MISSING : ST_TRUNCATED, r);
                        PH_SKIP, PH_PAD: got = abort_with(ST_MISSING, r);
                        PH_DATA:         got = abort_with(ST_OK, r);
                        default:         got = 1'b0;
                    endcase
                end
                clear();
            end
            if (got)
            begin
                due_results.push_back(r);
            end
        endfunction

        function void field_check(input string name, input logic [31:0] want,
                                  input logic [31:0] seen);
            if (seen !== want)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
                mismatch_count++;
            end
        endfunction

        function void match_result(input wav_out_t a);
            wav_out_t e;
            if (due_results.size() == 0)
            begin
                $error("result with nothing pending: kind %0d status %0d", a.kind, a.status);
                mismatch_count++;
                return;
            end
            e = due_results.pop_front();
            field_check("kind", 32'(e.kind), 32'(a.kind));
            field_check("sample", 32'(e.sample), 32'(a.sample));
            field_check("channel", 32'(e.channel), 32'(a.channel));
            field_check("channel_count", 32'(e.channel_count), 32'(a.channel_count));
            field_check("rate_hz", e.rate_hz, a.rate_hz);
            field_check("status", 32'(e.status), 32'(a.status));
            field_check("last", 32'(e.last), 32'(a.last));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               byte_valid = 1'b0;
    logic               byte_stall;
    logic [7:0]         data_byte = '0;
    logic               file_end = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic               channel;
    logic [1:0]         channel_count;
    logic [31:0]        rate_hz;
    logic [2:0]         status;
    logic               last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    wav_volume_checker wav_check;
    logic [7:0]        wav_bytes[$];
    wav_out_t          seen;
    int                cycle_count = 0;
    int                hold_left = 0;
    bit                hold_request = 1'b0;
    bit                tx_calm = 1'b0;
    bit                rx_calm = 1'b0;

    wav_stream_parse_and_volume dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .data_byte     (data_byte),
        .file_end      (file_end),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .kind          (kind),
        .sample        (sample),
        .channel       (channel),
        .channel_count (channel_count),
        .rate_hz       (rate_hz),
        .status        (status),
        .last          (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // result side: check each accepted transaction, then pick next stall
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            seen.kind = kind;
            seen.sample = sample;
            seen.channel = channel;
            seen.channel_count = channel_count;
            seen.rate_hz = rate_hz;
            seen.status = status;
            seen.last = last;
            wav_check.match_result(seen);
        end
        if (hold_request)
        begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            result_stall <= !rx_calm && ($urandom_range(99) < 18);
        end
    end

    function automatic void put_le16(input logic [15:0] v);
        wav_bytes.push_back(v[7:0]);
        wav_bytes.push_back(v[15:8]);
    endfunction

    function automatic void put_le32(input logic [31:0] v);
        put_le16(v[15:0]);
        put_le16(v[31:16]);
    endfunction

    function automatic void put_tag(input logic [31:0] t);
        wav_bytes.push_back(t[31:24]);
        wav_bytes.push_back(t[23:16]);
        wav_bytes.push_back(t[15:8]);
        wav_bytes.push_back(t[7:0]);
    endfunction

    function automatic void put_random(input int n);
        repeat (n) wav_bytes.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void trim_file(input int n);
        while (wav_bytes.size() > n) void'(wav_bytes.pop_back());
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void put_junk();
        int n;
        n = $urandom_range(0, 7);
        put_tag($urandom);
        put_le32(n);
        put_random(n + n % 2);
    endfunction

    function automatic void put_fmt(input int flen, input logic [15:0] fcode,
                                    input logic [15:0] chans, input logic [15:0] fbits);
        put_tag(TAG_FMT);
        put_le32(flen);
        if (flen < 16)
        begin
            put_random(flen);
        end
        else
        begin
            put_le16(fcode);
            put_le16(chans);
            put_le32($urandom);
            put_le32($urandom);
            put_le16(16'($urandom));
            put_le16(fbits);
            put_random(flen - 16);
        end
        put_random(flen % 2);
    endfunction

    function automatic void build_wav(input int flaw, input int nch, input logic [31:0] data_len,
                                      input int data_have, input int tail_len);
        logic [15:0] chans;
        logic [15:0] fcode;
        logic [15:0] fbits;
        int          flen;
        chans = 16'(nch);
        fcode = PCM_CODE;
        fbits = PCM_BITS;
        flen = ($urandom_range(1) == 0) ? 16 : 16 + $urandom_range(1, 6);
        case (flaw)
            FLAW_SHORT_FMT: flen = $urandom_range(0, 15);
            FLAW_BAD_CODE:  do fcode = 16'($urandom); while (fcode == PCM_CODE);
            FLAW_BAD_BITS:  do fbits = 16'($urandom); while (fbits == PCM_BITS);
            FLAW_BAD_CHANS:
            begin
                do chans = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
                while (chans == 1 || chans == 2);
            end
            default: ;
        endcase
        wav_bytes.delete();
        put_tag(flaw == FLAW_BAD_RIFF ? TAG_RIFF ^ (32'd1 << $urandom_range(31)) : TAG_RIFF);
        put_le32($urandom);
        put_tag(flaw == FLAW_BAD_WAVE ? TAG_WAVE ^ (32'd1 << $urandom_range(31)) : TAG_WAVE);
        if ($urandom_range(2) == 0)
        begin
            put_junk();
        end
        // an earlier fmt chunk with random fields, overwritten by the next one
        if (flaw == FLAW_REFMT)
        begin
            put_fmt(16, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        if (flaw != FLAW_NO_FMT)
        begin
            put_fmt(flen, fcode, chans, fbits);
        end
        if ($urandom_range(2) == 0)
        begin
            put_junk();
        end
        put_tag(TAG_DATA);
        put_le32(data_len);
        repeat ((data_have + 1) / 2) put_le16(pick_sample());
        if (data_have % 2)
        begin
            void'(wav_bytes.pop_back());
        end
        put_random(tail_len);
    endfunction

    function automatic void make_random_file();
        int pick;
        int nch;
        int dlen;
        int dhave;
        pick = $urandom_range(99);
        nch = $urandom_range(1, 2);
        dlen = $urandom_range(0, 24);
        dhave = ($urandom_range(99) < 85) ? dlen : $urandom_range(0, dlen + 4);
        if (pick < 60)
        begin
            build_wav(FLAW_NONE, nch, dlen, dhave,
                      ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
        end
        else if (pick < 72)
        begin
            build_wav(FLAW_NONE, nch, dlen, dhave, 0);
            trim_file($urandom_range(1, wav_bytes.size()));
        end
        else if (pick < 76)
        begin
            // declared data size far beyond the end of the file
            build_wav(FLAW_NONE, nch, $urandom, $urandom_range(0, 9), 0);
        end
        else if (pick < 82)
        begin
            wav_bytes.delete();
            if ($urandom_range(1))
            begin
                put_tag(TAG_RIFF);
                put_le32($urandom);
                put_tag(TAG_WAVE);
            end
            put_random($urandom_range(1, 20));
        end
        else
        begin
            build_wav($urandom_range(FLAW_BAD_RIFF, FLAW_REFMT), nch, dlen, dhave, 0);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fe);
        while (!tx_calm && $urandom_range(99) < 18)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte <= b;
        file_end <= fe;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        wav_check.take_byte(b, fe);
    endtask

    task automatic send_file();
        for (int i = 0; i < wav_bytes.size(); i++)
        begin
            send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
        end
    endtask

    // stop offering bytes and wait until every pending result is out
    task automatic quiesce();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (wav_check.due_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_volume(input logic [6:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_VOLUME);
        pwdata <= {25'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        wav_check.volume = v;
    endtask

    initial
    begin
        logic [6:0] vol_plan[6];
        int         sent;
        bit         paused;
        wav_check = new();
        vol_plan = '{7'd100, 7'd0, 7'd127, 7'd1, 7'd55, 7'd0};
        vol_plan[5] = 7'($urandom_range(0, 127));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed files at the reset volume
        build_wav(FLAW_NONE, 1, 10, 10, 0);
        send_file();
        build_wav(FLAW_NONE, 2, 9, 9, 3);
        send_file();
        build_wav(FLAW_NONE, 2, 0, 0, 2);
        send_file();
        build_wav(FLAW_NONE, 1, 20, 5, 0);
        send_file();
        for (int f = FLAW_BAD_RIFF; f <= FLAW_REFMT; f++)
        begin
            build_wav(f, 2, 6, 6, 0);
            send_file();
        end
        build_wav(FLAW_NONE, 1, 4, 4, 0);
        trim_file(5);
        send_file();
        build_wav(FLAW_NONE, 1, 4, 4, 0);
        trim_file(12);
        send_file();
        build_wav(FLAW_NONE, 1, 4, 4, 0);
        trim_file(16);
        send_file();
        build_wav(FLAW_NONE, 1, 4, 4, 0);
        trim_file(30);
        send_file();
        wav_bytes.delete();
        put_random(1);
        send_file();

        // gain extremes
        quiesce();
        write_volume(7'd127);
        build_wav(FLAW_NONE, 2, 16, 16, 0);
        send_file();
        quiesce();
        write_volume(7'd0);
        build_wav(FLAW_NONE, 1, 12, 12, 0);
        send_file();

        for (int p = 0; p < 6; p++)
        begin
            quiesce();
            write_volume(vol_plan[p]);
            tx_calm = (p == 2);
            rx_calm = (p == 2);
            // long receiver hold-off while bytes keep coming
            if (p == 3)
            begin
                hold_request = 1'b1;
            end
            paused = 1'b0;
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                make_random_file();
                send_file();
                sent += wav_bytes.size();
                if (p == 4 && !paused && sent > PHASE_BYTES / 2)
                begin
                    quiesce();
                    paused = 1'b1;
                end
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        quiesce();
        if (wav_check.mismatch_count == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

/* wav_stream_parse_and_volume.f */
rtl/core/wsp_pkg.sv
rtl/core/wav_stream_parse_and_volume.sv
dv/tb_top.sv
